@@ hw/rtl/bpp_pkg.sv @@
// Package for the blob position to polar converter: word types, fixed-point
// constants, the arctangent table and register codes.
// No dependencies.
package bpp_pkg;

   // Coordinate and offset widths
   localparam int COORD_BITS = 10;
   localparam int OFS_BITS   = COORD_BITS + 1;
   localparam int R2_BITS    = 2 * COORD_BITS + 1;
   localparam int R2C_BITS   = 16;
   localparam int R2_LIMIT   = 40000;

   // Rotation datapath
   localparam int CORD_STEPS = 16;
   localparam int CORD_W     = COORD_BITS + 20;
   localparam int ZW         = 26;
   localparam int Z90        = 90 * 65536;
   localparam logic [21:0] ATAN_Q16 [CORD_STEPS] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117304,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115
   };
   localparam int BEAR_OFS = 630;
   localparam int DEG_TURN = 360;

   // Range datapath
   localparam int ROOT_BITS = 24;
   localparam int REM_BITS  = 48;
   localparam int T_BITS    = 37;
   localparam int N_BITS    = 5;
   localparam int F_BITS    = 32;
   localparam int SUM_BITS  = 34;
   localparam int V_BITS    = 59;
   localparam int TERMS     = 16;
   localparam int ROUND_POS = 55;
   localparam int RANGE_OFS = 100;
   localparam logic [31:0] LN2_Q32    = 32'd2977044472;
   localparam logic [24:0] BALL_A_Q24 = 25'd25890600;
   localparam logic [24:0] GOAL_A_Q24 = 25'd26107026;
   localparam logic [28:0] BALL_B_Q32 = 29'd277454887;
   localparam logic [28:0] GOAL_B_Q32 = 29'd270153443;

   // Register file
   localparam int ADDR_BITS = 3;
   localparam logic [COORD_BITS-1:0] CENTRE_X_RESET = COORD_BITS'(80);
   localparam logic [COORD_BITS-1:0] CENTRE_Y_RESET = COORD_BITS'(60);
   localparam logic [ADDR_BITS-3:0] REG_CENTRE_X = 1'b0;
   localparam logic [ADDR_BITS-3:0] REG_CENTRE_Y = 1'b1;

   typedef struct packed {
      logic                  op;
      logic                  visible;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_word_type;

   typedef struct packed {
      logic [8:0]  bearing;
      logic [15:0] range;
   } rsp_word_type;

endpackage

@@ hw/rtl/blob_position_to_polar_top.sv @@
// Blob position to polar converter: pipelined rotation for the bearing and
// square root, exponential series and scaling for the calibrated range.
// Depends on bpp_pkg.
//
// Usage:
//   Request words (op, visible, pixel_x, pixel_y) enter on req_valid while
//   req_stall is low; result words (bearing, range) leave on rsp_valid while
//   rsp_stall is low. One result word per request word, in order. The user
//   must write centre_x and centre_y (byte address 0 and 4, reset 80 and 60)
//   over the register port only while no word is in flight (not enforced).
// Throughput and depth:
//   A new word is taken every cycle while req_stall is low; the 64-stage
//   datapath (16 rotation steps beside 24 root steps, a 5-step divide by
//   ln2 and 15 two-stage series terms) sets depth.
// Reset:
//   Clears all valid bits, including those of the skid and output registers,
//   and returns the centre to 80 and 60.
// Receiver stall:
//   The output register holds; one more word drops into a skid register, then
//   req_stall rises and the whole pipeline holds until the skid drains.
module blob_position_to_polar_top
   import bpp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_word_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_word,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   // Stage map
   localparam int ST_PRE    = 1;
   localparam int ST_CORD   = 2;
   localparam int ST_ROUND  = ST_CORD + CORD_STEPS;
   localparam int ST_BEAR   = ST_ROUND + 1;
   localparam int ST_SQRT   = 2;
   localparam int ST_MUL_T  = ST_SQRT + ROOT_BITS;
   localparam int ST_DIV    = ST_MUL_T + 1;
   localparam int ST_EXP1   = ST_DIV + N_BITS;
   localparam int ST_TERM   = ST_EXP1 + 1;
   localparam int ST_SCALE  = ST_TERM + 2 * (TERMS - 1);
   localparam int NST       = ST_SCALE + 1;

   typedef struct packed {
      logic                       op;
      logic                       visible;
      logic                       big;
      logic                       zero;
      logic signed [OFS_BITS-1:0] ofs_x;
      logic signed [OFS_BITS-1:0] ofs_y;
      logic signed [CORD_W-1:0]   cx;
      logic signed [CORD_W-1:0]   cy;
      logic signed [ZW-1:0]       cz;
      logic signed [8:0]          deg;
      logic [8:0]                 bear;
      logic [REM_BITS-1:0]        rem;
      logic [ROOT_BITS-1:0]       root;
      logic [T_BITS-1:0]          t;
      logic [N_BITS-1:0]          n;
      logic [F_BITS-1:0]          f;
      logic [F_BITS-1:0]          term;
      logic [F_BITS-1:0]          p;
      logic [SUM_BITS-1:0]        sum;
      logic [V_BITS-1:0]          v;
   } stage_type;

   logic [COORD_BITS-1:0] centre_x_ff, centre_x_in;
   logic [COORD_BITS-1:0] centre_y_ff, centre_y_in;
   stage_type             pipe_ff [NST];
   stage_type             pipe_in [NST];
   logic [NST-1:0]        pipe_v_ff;
   rsp_word_type          out_ff, skid_ff, res;
   logic                  out_v_ff, skid_v_ff;
   logic                  adv, take;
   logic                  csr_wr;

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      if (csr_wr) begin
         case (paddr[ADDR_BITS-1:2])
            REG_CENTRE_X: centre_x_in = pwdata[COORD_BITS-1:0];
            REG_CENTRE_Y: centre_y_in = pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[ADDR_BITS-1:2])
         REG_CENTRE_X: prdata = 32'(centre_x_ff);
         REG_CENTRE_Y: prdata = 32'(centre_y_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= CENTRE_X_RESET;
         centre_y_ff <= CENTRE_Y_RESET;
      end else begin
         centre_x_ff <= centre_x_in;
         centre_y_ff <= centre_y_in;
      end
   end

   // Hold the whole pipeline while the skid register is full
   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign take      = !out_v_ff || !rsp_stall;

   // Capture the word and form offsets from the centre
   always_comb begin
      pipe_in[0]         = '0;
      pipe_in[0].op      = req_word.op;
      pipe_in[0].visible = req_word.visible;
      pipe_in[0].ofs_x   = $signed({1'b0, centre_x_ff}) - $signed({1'b0, req_word.pixel_x});
      pipe_in[0].ofs_y   = $signed({1'b0, centre_y_ff}) - $signed({1'b0, req_word.pixel_y});
   end

   for (genvar s = 1; s < NST; s++) begin : g_stage
      localparam int S  = s;
      localparam int CI = (S >= ST_CORD && S < ST_ROUND) ? S - ST_CORD : 0;
      localparam int SB = (S >= ST_SQRT && S < ST_MUL_T) ? ROOT_BITS - 1 - (S - ST_SQRT) : 0;
      localparam int DJ = (S >= ST_DIV && S < ST_EXP1) ? N_BITS - 1 - (S - ST_DIV) : 0;
      localparam int TP = (S >= ST_TERM && S < ST_SCALE) ? (S - ST_TERM) % 2 : 0;
      localparam int K  = (S >= ST_TERM && S < ST_SCALE) ? (S - ST_TERM) / 2 + 2 : 2;
      localparam logic [REM_BITS+1:0] SQ_ADD = (REM_BITS + 2)'(1) << (2 * SB);
      localparam logic [T_BITS-1:0]   DIV_D  = T_BITS'(LN2_Q32) << DJ;
      localparam logic [36:0]         RECIP  =
         37'(((64'd1 << 36) + 64'(K) - 64'd1) / 64'(K));

      always_comb begin : calc
         stage_type                    pv;
         logic signed [CORD_W-1:0]     xs, ys, xw, yw;
         logic signed [ZW-1:0]         atan_z, zr, zq;
         logic signed [2*OFS_BITS-1:0] sqx, sqy;
         logic [R2_BITS-1:0]           r2;
         logic [REM_BITS+1:0]          trial;
         logic [52:0]                  t_prod;
         logic [63:0]                  tf_prod;
         logic [68:0]                  q_prod;
         logic [10:0]                  bw;
         pv     = pipe_ff[S-1];
         xs     = '0;
         ys     = '0;
         xw     = '0;
         yw     = '0;
         atan_z = '0;
         zr     = '0;
         zq     = '0;
         sqx    = '0;
         sqy    = '0;
         r2     = '0;
         trial  = '0;
         t_prod = '0;
         tf_prod = '0;
         q_prod = '0;
         bw     = '0;
         pipe_in[S] = pv;

         // Squared radius, root setup and quadrant pre-rotation
         if (S == ST_PRE) begin
            sqx = pv.ofs_x * pv.ofs_x;
            sqy = pv.ofs_y * pv.ofs_y;
            r2  = R2_BITS'(sqx) + R2_BITS'(sqy);
            pipe_in[S].big  = (r2 > R2_LIMIT);
            pipe_in[S].rem  = {(pipe_in[S].big ? R2C_BITS'(0) : R2C_BITS'(r2)), 32'd0};
            pipe_in[S].root = '0;
            pipe_in[S].zero = (pv.ofs_x == 0) && (pv.ofs_y == 0);
            xw = CORD_W'(pv.ofs_x) <<< 16;
            yw = CORD_W'(pv.ofs_y) <<< 16;
            if (pv.ofs_x < 0) begin
               if (pv.ofs_y >= 0) begin
                  pipe_in[S].cx = yw;
                  pipe_in[S].cy = -xw;
                  pipe_in[S].cz = ZW'(Z90);
               end else begin
                  pipe_in[S].cx = -yw;
                  pipe_in[S].cy = xw;
                  pipe_in[S].cz = -ZW'(Z90);
               end
            end else begin
               pipe_in[S].cx = xw;
               pipe_in[S].cy = yw;
               pipe_in[S].cz = '0;
            end
         end

         // One rotation step, shifts truncate toward zero
         if (S >= ST_CORD && S < ST_ROUND) begin
            xs = pv.cx[CORD_W-1] ? -((-pv.cx) >>> CI) : (pv.cx >>> CI);
            ys = pv.cy[CORD_W-1] ? -((-pv.cy) >>> CI) : (pv.cy >>> CI);
            atan_z = ZW'(ATAN_Q16[CI]);
            if (pv.cy > 0) begin
               pipe_in[S].cx = pv.cx + ys;
               pipe_in[S].cy = pv.cy - xs;
               pipe_in[S].cz = pv.cz + atan_z;
            end else begin
               pipe_in[S].cx = pv.cx - ys;
               pipe_in[S].cy = pv.cy + xs;
               pipe_in[S].cz = pv.cz - atan_z;
            end
         end

         // Round the angle to whole degrees, half away from zero
         if (S == ST_ROUND) begin
            zr = ((pv.cz >= 0) ? pv.cz : -pv.cz) + ZW'(32768);
            zq = zr >>> 16;
            if (pv.zero) begin
               pipe_in[S].deg = '0;
            end else if (pv.cz >= 0) begin
               pipe_in[S].deg = 9'(zq);
            end else begin
               pipe_in[S].deg = -9'(zq);
            end
         end

         // Turn the angle into the bearing
         if (S == ST_BEAR) begin
            bw = 11'(BEAR_OFS) - 11'(pv.deg);
            if (bw >= 11'(2 * DEG_TURN)) begin
               pipe_in[S].bear = 9'(bw - 11'(2 * DEG_TURN));
            end else if (bw >= 11'(DEG_TURN)) begin
               pipe_in[S].bear = 9'(bw - 11'(DEG_TURN));
            end else begin
               pipe_in[S].bear = 9'(bw);
            end
         end

         // One root bit per stage
         if (S >= ST_SQRT && S < ST_MUL_T) begin
            trial = ((REM_BITS + 2)'(pv.root) << (SB + 1)) + SQ_ADD;
            if ((REM_BITS + 2)'(pv.rem) >= trial) begin
               pipe_in[S].rem      = pv.rem - trial[REM_BITS-1:0];
               pipe_in[S].root[SB] = 1'b1;
            end
         end

         // Exponent argument t = b * r
         if (S == ST_MUL_T) begin
            t_prod = pv.root * (pv.op ? GOAL_B_Q32 : BALL_B_Q32);
            pipe_in[S].t = t_prod[52:16];
            pipe_in[S].n = '0;
         end

         // One quotient bit of t / ln2 per stage
         if (S >= ST_DIV && S < ST_EXP1) begin
            if (pv.t >= DIV_D) begin
               pipe_in[S].t     = pv.t - DIV_D;
               pipe_in[S].n[DJ] = 1'b1;
            end
         end

         // First series term
         if (S == ST_EXP1) begin
            pipe_in[S].f    = pv.t[F_BITS-1:0];
            pipe_in[S].term = pv.t[F_BITS-1:0];
            pipe_in[S].sum  = (SUM_BITS'(1) << 32) + SUM_BITS'(pv.t[F_BITS-1:0]);
         end

         // Series term: multiply by f, then divide by k through its reciprocal
         if (S >= ST_TERM && S < ST_SCALE) begin
            if (TP == 0) begin
               tf_prod      = 64'(pv.term) * 64'(pv.f);
               pipe_in[S].p = tf_prod[63:32];
            end else begin
               q_prod          = 69'(pv.p) * 69'(RECIP);
               pipe_in[S].term = q_prod[67:36];
               pipe_in[S].sum  = pv.sum + SUM_BITS'(q_prod[67:36]);
            end
         end

         // Scale by the curve coefficient
         if (S == ST_SCALE) begin
            pipe_in[S].v = V_BITS'(pv.sum) * V_BITS'(pv.op ? GOAL_A_Q24 : BALL_A_Q24);
         end
      end
   end

   // Apply 2^n, round, offset and saturate
   always_comb begin : finish
      logic [5:0]        sh;
      logic [V_BITS-1:0] shv;
      logic [22:0]       rnd, half, ofs;
      sh   = 6'(ROUND_POS) - 6'(pipe_ff[NST-1].n);
      shv  = pipe_ff[NST-1].v >> sh;
      rnd  = 23'(shv[21:0]) + 23'd1;
      half = rnd >> 1;
      ofs  = half + 23'(RANGE_OFS);
      res.bearing = pipe_ff[NST-1].visible ? pipe_ff[NST-1].bear : '0;
      if (!pipe_ff[NST-1].visible) begin
         res.range = '0;
      end else if (pipe_ff[NST-1].big || ofs > 23'(16'hFFFF)) begin
         res.range = 16'hFFFF;
      end else begin
         res.range = ofs[15:0];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NST; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
      end else if (adv) begin
         pipe_v_ff <= {pipe_v_ff[NST-2:0], req_valid};
      end
   end

   // Output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= pipe_v_ff[NST-1];
         end
      end else if (adv && pipe_v_ff[NST-1]) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= skid_v_ff ? skid_ff : res;
      end else if (adv) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_word  = out_ff;

   // Checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid full while output register empty");

   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.bearing < 9'(DEG_TURN)))
      else $error("bearing out of range");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(rsp_stall))
      else $error("skid filled without a stall");

   a_hold_on_skid: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(pipe_v_ff))
      else $error("pipeline moved while skid full");

endmodule

@@ tb/sv/blob_position_to_polar_checker.sv @@
// Result checker for the blob position to polar converter: watches both word
// channels and the register port, predicts bearing and range, compares.
// Depends on bpp_pkg.
`timescale 1ns / 100ps

module blob_position_to_polar_checker
   import bpp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_word_type         req_word,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_word_type         rsp_word,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic                 pready,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output int                   fail_count,
   output int                   words_pending
);

   logic [COORD_BITS-1:0] centre_x_q;
   logic [COORD_BITS-1:0] centre_y_q;
   rsp_word_type          polar_queue[$];

   // Rotation of the centre offset, rounded to whole degrees
   function automatic int offset_angle(int dx, int dy);
      longint x, y, z, tx, xs, ys;
      x = longint'(dx) * 65536;
      y = longint'(dy) * 65536;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (x < 0) begin
         tx = x;
         if (y >= 0) begin
            x = y; y = -tx; z = Z90;
         end else begin
            x = -y; y = tx; z = -Z90;
         end
      end
      for (int i = 0; i < CORD_STEPS; i++) begin
         xs = x / (longint'(1) << i);
         ys = y / (longint'(1) << i);
         if (y > 0) begin
            x += ys; y -= xs; z += longint'(ATAN_Q16[i]);
         end else begin
            x -= ys; y += xs; z -= longint'(ATAN_Q16[i]);
         end
      end
      if (z >= 0) return int'((z + 32768) / 65536);
      return -int'((-z + 32768) / 65536);
   endfunction

   // Integer square root of a 64-bit value
   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Exponential range curve, rounded and saturated
   function automatic logic [15:0] curve_range(longint unsigned r2, logic goal);
      longint unsigned a, b, r16, t, n, f, sum, term, v, res;
      int unsigned sh;
      a = goal ? longint'(GOAL_A_Q24) : longint'(BALL_A_Q24);
      b = goal ? longint'(GOAL_B_Q32) : longint'(BALL_B_Q32);
      if (r2 > R2_LIMIT) return 16'hFFFF;
      r16 = root64(r2 << 32);
      t = (r16 * b) >> 16;
      n = t / longint'(LN2_Q32);
      f = t - n * longint'(LN2_Q32);
      sum = longint'(1) << 32;
      term = longint'(1) << 32;
      for (int k = 1; k <= TERMS; k++) begin
         term = ((term * f) >> 32) / longint'(k);
         sum += term;
      end
      v = a * sum;
      sh = 56 - int'(n);
      res = ((v >> (sh - 1)) + 1) >> 1;
      res += RANGE_OFS;
      return (res > 65535) ? 16'hFFFF : res[15:0];
   endfunction

   function automatic rsp_word_type blob_polar(req_word_type w);
      rsp_word_type p;
      int dx, dy, deg, brg;
      p = '0;
      if (!w.visible) return p;
      dx = int'(centre_x_q) - int'(w.pixel_x);
      dy = int'(centre_y_q) - int'(w.pixel_y);
      deg = offset_angle(dx, dy);
      brg = (BEAR_OFS - deg) % DEG_TURN;
      if (brg < 0) brg += DEG_TURN;
      p.bearing = brg[8:0];
      p.range = curve_range(longint'(dx * dx + dy * dy), w.op);
      return p;
   endfunction

   // Track centre writes, predict on each taken word, compare on each result
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         centre_x_q <= CENTRE_X_RESET;
         centre_y_q <= CENTRE_Y_RESET;
         polar_queue.delete();
         fail_count <= 0;
         words_pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[ADDR_BITS-1:2] == REG_CENTRE_X) centre_x_q <= pwdata[COORD_BITS-1:0];
            if (paddr[ADDR_BITS-1:2] == REG_CENTRE_Y) centre_y_q <= pwdata[COORD_BITS-1:0];
         end
         if (req_valid && !req_stall) polar_queue.push_back(blob_polar(req_word));
         if (rsp_valid && !rsp_stall) begin
            if (polar_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word: bearing %0d range %0d",
                           rsp_word.bearing, rsp_word.range);
               fail_count <= fail_count + 1;
            end else begin
               want = polar_queue.pop_front();
               if (want != rsp_word) begin
                  if (fail_count < 10)
                     $display("mismatch: bearing exp %0d got %0d, range exp %0d got %0d",
                              want.bearing, rsp_word.bearing, want.range, rsp_word.range);
                  fail_count <= fail_count + 1;
               end
            end
         end
         words_pending <= polar_queue.size();
      end
   end

endmodule

@@ tb/sv/blob_position_to_polar_top_tb.sv @@
// Testbench top for the blob position to polar converter: clock, reset,
// stimulus words, register writes, idle phases and the verdict.
// Depends on bpp_pkg, blob_position_to_polar_top and the checker module.
`timescale 1ns / 100ps

module blob_position_to_polar_top_tb;
   import bpp_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 80;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_word_type         req_word;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_word_type         rsp_word;
   logic                 psel, penable, pwrite, pready;
   logic [ADDR_BITS-1:0] paddr;
   logic [31:0]          pwdata, prdata;
   int                   fail_count, words_pending;

   logic req_taken;
   int   send_idle_pct, rsp_stall_pct, quiet_cycles;
   int   cur_cx, cur_cy;

   blob_position_to_polar_top u_dut (.*);

   blob_position_to_polar_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_word, .rsp_valid, .rsp_stall,
      .rsp_word, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .words_pending
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Note the request handshake, and abort on a long quiet stretch
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic send_word(input req_word_type w);
      while (req_valid && !req_taken) @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(negedge clock);
   endtask

   // Hold until the last word is taken and every result has come back
   task automatic drain_words();
      while (req_valid && !req_taken) @(negedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
   endtask

   task automatic write_centre(input logic [ADDR_BITS-3:0] idx, input int value);
      drain_words();
      repeat (DRAIN_CYCLES) @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == REG_CENTRE_X) cur_cx = value;
      else cur_cy = value;
   endtask

   function automatic req_word_type blob_word(int op, int vis, int px, int py);
      req_word_type w;
      w.op = op[0];
      w.visible = vis[0];
      w.pixel_x = px[COORD_BITS-1:0];
      w.pixel_y = py[COORD_BITS-1:0];
      return w;
   endfunction

   // Mostly near the centre so the range curve is exercised, else anywhere
   function automatic int near_coord(int centre);
      int c;
      if ($urandom_range(99) < 30) return $urandom_range(1023);
      c = centre + $urandom_range(440) - 220;
      if (c < 0) c = 0;
      if (c > 1023) c = 1023;
      return c;
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_word(blob_word($urandom_range(1), ($urandom_range(9) != 0),
                             near_coord(cur_cx), near_coord(cur_cy)));
   endtask

   int cx_set[5] = '{0, 1023, 512, 80, 300};
   int cy_set[5] = '{0, 1023, 512, 60, 700};
   int idle_set[4] = '{0, 72, 0, 16};
   int stall_set[4] = '{0, 0, 72, 16};

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_word = '0; rsp_stall = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      send_idle_pct = 0; rsp_stall_pct = 0;
      cur_cx = 80; cur_cy = 60;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words at the reset centre
      send_word(blob_word(0, 0, 123, 45));
      send_word(blob_word(1, 0, 1023, 1023));
      send_word(blob_word(0, 1, 80, 60));
      send_word(blob_word(1, 1, 80, 60));
      send_word(blob_word(0, 1, 0, 0));
      send_word(blob_word(1, 1, 1023, 1023));
      send_word(blob_word(0, 1, 1023, 0));
      send_word(blob_word(1, 1, 0, 1023));
      send_word(blob_word(0, 1, 80, 0));
      send_word(blob_word(0, 1, 80, 120));
      send_word(blob_word(1, 1, 0, 60));
      send_word(blob_word(1, 1, 160, 60));
      send_word(blob_word(0, 1, 280, 60));
      send_word(blob_word(1, 1, 280, 60));
      send_word(blob_word(0, 1, 281, 60));
      send_word(blob_word(1, 1, 80, 260));
      send_word(blob_word(0, 1, 70, 70));
      send_word(blob_word(1, 1, 90, 50));
      send_word(blob_word(0, 1, 90, 70));
      send_word(blob_word(1, 1, 70, 50));
      send_word(blob_word(0, 1, 81, 60));

      // Random words over several centres and idle patterns
      for (int s = 0; s < 5; s++) begin
         write_centre(REG_CENTRE_X, cx_set[s]);
         write_centre(REG_CENTRE_Y, cy_set[s]);
         for (int m = 0; m < 4; m++) begin
            send_idle_pct = idle_set[m];
            rsp_stall_pct = stall_set[m];
            send_random(31);
            if (m == 1) drain_words();
            send_random(31);
         end
      end

      drain_words();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
